[hw/rtl/imu_ufp_pkg.sv]
// Shared types and constants for the IMU serial frame parser.
// Holds the per-channel context layout, the result record and register indexes.
// No dependencies.
`default_nettype none

package imu_ufp_pkg;

  localparam int CHANNELS_DEF = 2;
  localparam int FRAME_BYTES  = 9;
  localparam int FRAME_LEN    = 10;
  localparam int FRAME_W      = 8 * FRAME_BYTES;

  localparam logic [7:0] HEADER_RESET    = 8'h55;
  localparam logic [7:0] TYPE_BASE_RESET = 8'h51;

  typedef enum logic [0:0] {
    REG_HEADER    = 1'b0,
    REG_TYPE_BASE = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [3:0]         pos;
    logic [2:0]         mask;
    logic [FRAME_W-1:0] frame;
  } ctx_t;

  typedef struct packed {
    logic               source_channel;
    logic [1:0]         kind;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] temperature;
    logic               set_complete;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/imu_ufp_ctx_mem.sv]
// Per-channel context memory with one write port and one registered read port.
// Entries not yet written read with position and seen mask as zero.
// Depends on imu_ufp_pkg.
`default_nettype none

module imu_ufp_ctx_mem #(
  parameter int DEPTH = imu_ufp_pkg::CHANNELS_DEF,
  parameter int AW    = 1
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 we,
  input  wire [AW-1:0]        waddr,
  input  imu_ufp_pkg::ctx_t   wdata,
  input  wire                 re,
  input  wire [AW-1:0]        raddr,
  output imu_ufp_pkg::ctx_t   rdata
);
  import imu_ufp_pkg::*;

  ctx_t             mem [DEPTH];
  logic [DEPTH-1:0] vld;
  ctx_t             rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld_q <= vld[raddr];
      end
    end
  end

  always_comb begin
    rdata = rd_q;
    if (!rd_vld_q) begin
      rdata.pos  = '0;
      rdata.mask = '0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/imu_ufp_update.sv]
// Read-modify step for one channel context: header hunt, byte capture and decode.
// Combinational; depends on imu_ufp_pkg.
`default_nettype none

module imu_ufp_update (
  input  imu_ufp_pkg::ctx_t cur,
  input  wire               channel,
  input  wire [7:0]         rx_byte,
  input  wire [7:0]         header_value,
  input  wire [7:0]         type_base,
  output imu_ufp_pkg::ctx_t nxt,
  output logic              has_res,
  output imu_ufp_pkg::res_t res
);
  import imu_ufp_pkg::*;

  logic [7:0] ftype;
  logic [8:0] diff;
  logic       match;
  logic [2:0] mask_set;

  assign ftype = cur.frame[7:0];
  assign diff  = {1'b0, ftype} - {1'b0, type_base};
  assign match = (ftype >= type_base) && (diff <= 9'd2);

  always_comb begin
    nxt      = cur;
    has_res  = 1'b0;
    mask_set = cur.mask | (3'b001 << diff[1:0]);

    res.source_channel = channel;
    res.kind           = diff[1:0];
    res.axis_x         = {cur.frame[23:16], cur.frame[15:8]};
    res.axis_y         = {cur.frame[39:32], cur.frame[31:24]};
    res.axis_z         = {cur.frame[55:48], cur.frame[47:40]};
    res.temperature    = {cur.frame[71:64], cur.frame[63:56]};
    res.set_complete   = 1'b0;

    if (cur.pos == 4'd0) begin
      if (rx_byte == header_value) begin
        nxt.pos = 4'd1;
      end
    end else if (cur.pos < 4'(FRAME_LEN)) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        if (cur.pos == 4'(i + 1)) begin
          nxt.frame[8*i +: 8] = rx_byte;
        end
      end
      nxt.pos = cur.pos + 4'd1;
    end else begin
      nxt.pos = 4'd0;
      if (match) begin
        has_res = 1'b1;
        if (mask_set == 3'b111) begin
          res.set_complete = 1'b1;
          nxt.mask         = 3'b000;
        end else begin
          nxt.mask = mask_set;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/imu_uart_frame_parser.sv]
// IMU serial frame parser, top level. A frame is decoded as its channel's next byte passes
// stage one; the result is then registered. Throughput: one byte per cycle while in_stall is
// low, set by the read-modify-write of the context memory, which forwards its last write to
// the next byte. Reset clears the pipeline, out_valid, the per-entry valid bits (so every
// channel hunts with an empty seen mask) and sets the registers to 0x55 and 0x51; no clearing
// pass. Depends on imu_ufp_pkg, imu_ufp_ctx_mem and imu_ufp_update.
`default_nettype none

module imu_uart_frame_parser #(
  parameter int CHANNELS = imu_ufp_pkg::CHANNELS_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_write,
  input  wire               cfg_index,
  input  wire [7:0]         cfg_data,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               channel,
  input  wire [7:0]         rx_byte,
  output logic              out_valid,
  input  wire               out_stall,
  output logic              source_channel,
  output logic [1:0]        kind,
  output logic signed [15:0] axis_x,
  output logic signed [15:0] axis_y,
  output logic signed [15:0] axis_z,
  output logic signed [15:0] temperature,
  output logic              set_complete
);
  import imu_ufp_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [7:0] header_value;
  logic [7:0] type_base;

  logic          accept;
  logic          ch_ok;
  logic [AW-1:0] in_addr;

  logic          s1_valid;
  logic          s1_ch;
  logic [7:0]    s1_byte;
  logic [AW-1:0] s1_addr;
  logic          s1_go;

  ctx_t          rd_ctx;
  ctx_t          cur;
  ctx_t          nxt;
  logic          has_res;
  res_t          res;
  logic          out_free;

  logic          last_valid;
  logic [AW-1:0] last_addr;
  ctx_t          last_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= HEADER_RESET;
      type_base    <= TYPE_BASE_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_HEADER:    header_value <= cfg_data;
        REG_TYPE_BASE: type_base    <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign ch_ok    = 32'(channel) < CHANNELS;
  assign in_addr  = AW'(channel);
  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && (!has_res || out_free);
  assign in_stall = s1_valid && !s1_go;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= ch_ok;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch   <= channel;
      s1_byte <= rx_byte;
      s1_addr <= in_addr;
    end
  end

  imu_ufp_ctx_mem #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_ctx_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (s1_go),
    .waddr (s1_addr),
    .wdata (nxt),
    .re    (accept),
    .raddr (in_addr),
    .rdata (rd_ctx)
  );

  // For back-to-back bytes, the write of the previous byte lands at the same edge as this byte's read.
  always_comb begin
    cur = rd_ctx;
    if (last_valid && last_addr == s1_addr) begin
      cur = last_ctx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
    end else if (s1_go) begin
      last_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      last_addr <= s1_addr;
      last_ctx  <= nxt;
    end
  end

  imu_ufp_update u_update (
    .cur          (cur),
    .channel      (s1_ch),
    .rx_byte      (s1_byte),
    .header_value (header_value),
    .type_base    (type_base),
    .nxt          (nxt),
    .has_res      (has_res),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid && has_res) begin
      source_channel <= res.source_channel;
      kind           <= res.kind;
      axis_x         <= res.axis_x;
      axis_y         <= res.axis_y;
      axis_z         <= res.axis_z;
      temperature    <= res.temperature;
      set_complete   <= res.set_complete;
    end
  end

endmodule

`default_nettype wire
